// ===== sv/rtfb_pkg.sv =====
// ---------------------------------------------------------------------------
// rtfb_pkg: shared types and constants for the radio transmit frame builder
// Request and result word types, register indices, frame layout constants.
// ---------------------------------------------------------------------------
package rtfb_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN = 24;
    localparam int unsigned CNT_W     = $clog2(FRAME_LEN);

    // Fixed frame bytes
    localparam logic [7:0] BYTE_DELIM    = 8'h7E;
    localparam logic [7:0] BYTE_LEN_HI   = 8'h00;
    localparam logic [7:0] BYTE_LEN_LO   = 8'h14;
    localparam logic [7:0] BYTE_API_ID   = 8'h01;
    localparam logic [7:0] BYTE_FRAME_ID = 8'h01;
    localparam logic [7:0] BYTE_OPTION   = 8'h00;
    localparam logic [7:0] BYTE_TAG_A    = 8'hAF;
    localparam logic [7:0] BYTE_TAG_B    = 8'hFB;
    localparam logic [7:0] BYTE_FULL     = 8'hFF;

    // Register reset values
    localparam logic [15:0] FOLLOWER0_RST = 16'h3333;
    localparam logic [15:0] FOLLOWER1_RST = 16'h4444;
    localparam logic [15:0] FOLLOWER2_RST = 16'h5555;

    // Configuration port widths
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOLLOWER0   = 3'd0,
        CFG_FOLLOWER1   = 3'd1,
        CFG_FOLLOWER2   = 3'd2,
        CFG_WAYPT_OFF   = 3'd3,
        CFG_ORBIT_OFF   = 3'd4
    } cfg_idx_t;

    // Follower selection codes
    localparam logic [1:0] FOLLOWER_0 = 2'd0;
    localparam logic [1:0] FOLLOWER_1 = 2'd1;
    localparam logic [1:0] FOLLOWER_2 = 2'd2;

    // Packet kinds
    localparam logic [7:0] KIND_WAYPOINT = 8'd0;
    localparam logic [7:0] KIND_ORBIT    = 8'd1;

    // Request word
    typedef struct packed {
        logic [1:0]         follower_id;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic signed [31:0] altitude;
        logic [7:0]         packet_kind;
    } req_t;

    // Result word
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } res_t;

    typedef logic [FRAME_LEN-1:0][7:0] frame_t;

endpackage

// ===== sv/radio_tx_frame_builder.sv =====
// ---------------------------------------------------------------------------
// radio_tx_frame_builder: 24-byte API transmit frame builder
// Builds an addressed position frame from one request word and streams it
// out a byte a cycle with an end flag on the last byte.
// ---------------------------------------------------------------------------
//  Channel   Signals                            Handshake
//  -------   --------------------------------   -------------------------------
//  request   start, busy, req                   taken when start && !busy
//  result    strobe, result                     one byte per cycle, no stall
//  config    cfg_write, cfg_index, cfg_data     written when cfg_write is high
//
//  A request is registered on acceptance, the whole frame is formed from that
//  register combinationally and loaded into a byte shift register, which puts
//  out 24 bytes on consecutive cycles and so sets the rate. A request waiting
//  behind a frame is loaded on its last byte, so frames follow without a gap.
//  When idle, the first byte appears once the request has passed the holding
//  register and then the shift register. Reset restores the register defaults
//  and empties both stages. The receiver cannot stall the byte stream.
// ---------------------------------------------------------------------------
module radio_tx_frame_builder
    import rtfb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  req,
    output logic                  strobe,
    output res_t                  result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [15:0] follower0_reg;
    logic [15:0] follower1_reg;
    logic [15:0] follower2_reg;
    logic [7:0]  waypt_off_reg;
    logic [7:0]  orbit_off_reg;

    // Request holding stage
    logic pend_reg;
    logic pend_next;
    req_t req_reg;

    // Byte serialiser
    logic             act_reg;
    logic             act_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    frame_t           frame_reg;
    frame_t           frame_next;

    logic   accept;
    logic   last;
    logic   load;
    logic [15:0] addr;
    logic [7:0]  pos_sum;
    logic [7:0]  type_tag;
    logic [7:0]  hdr_sum;
    logic [7:0]  check;
    frame_t      frame_built;

    assign accept = start && !busy;
    assign busy   = pend_reg;
    assign last   = act_reg && (cnt_reg == CNT_W'(FRAME_LEN - 1));
    assign load   = pend_reg && (!act_reg || last);

    // Configuration writes; indices beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follower0_reg <= FOLLOWER0_RST;
            follower1_reg <= FOLLOWER1_RST;
            follower2_reg <= FOLLOWER2_RST;
            waypt_off_reg <= '0;
            orbit_off_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FOLLOWER0: follower0_reg <= cfg_data;
                CFG_FOLLOWER1: follower1_reg <= cfg_data;
                CFG_FOLLOWER2: follower2_reg <= cfg_data;
                CFG_WAYPT_OFF: waypt_off_reg <= cfg_data[7:0];
                CFG_ORBIT_OFF: orbit_off_reg <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    // Destination address; the unused follower id sends a zero address
    always_comb
    begin
        case (req_reg.follower_id)
            FOLLOWER_0: addr = follower0_reg;
            FOLLOWER_1: addr = follower1_reg;
            FOLLOWER_2: addr = follower2_reg;
            default:    addr = '0;
        endcase
    end

    // Byte sum of the twelve position bytes, as a balanced tree
    assign pos_sum = ((req_reg.latitude[7:0]    + req_reg.latitude[15:8])
                    + (req_reg.latitude[23:16]  + req_reg.latitude[31:24]))
                   + ((req_reg.longitude[7:0]   + req_reg.longitude[15:8])
                    + (req_reg.longitude[23:16] + req_reg.longitude[31:24]))
                   + ((req_reg.altitude[7:0]    + req_reg.altitude[15:8])
                    + (req_reg.altitude[23:16]  + req_reg.altitude[31:24]));

    // Type tag
    always_comb
    begin
        case (req_reg.packet_kind)
            KIND_WAYPOINT: type_tag = BYTE_FULL - pos_sum + waypt_off_reg;
            KIND_ORBIT:    type_tag = BYTE_FULL - pos_sum + orbit_off_reg;
            default:       type_tag = '0;
        endcase
    end

    // Checksum over bytes 3 to 22
    assign hdr_sum = (BYTE_API_ID + BYTE_FRAME_ID) + (addr[15:8] + addr[7:0])
                   + (BYTE_OPTION + BYTE_TAG_A) + BYTE_TAG_B;
    assign check   = BYTE_FULL - ((hdr_sum + pos_sum) + type_tag);

    // Whole frame, index 0 sent first
    always_comb
    begin
        frame_built[0]  = BYTE_DELIM;
        frame_built[1]  = BYTE_LEN_HI;
        frame_built[2]  = BYTE_LEN_LO;
        frame_built[3]  = BYTE_API_ID;
        frame_built[4]  = BYTE_FRAME_ID;
        frame_built[5]  = addr[15:8];
        frame_built[6]  = addr[7:0];
        frame_built[7]  = BYTE_OPTION;
        frame_built[8]  = BYTE_TAG_A;
        frame_built[9]  = BYTE_TAG_B;
        frame_built[10] = req_reg.latitude[7:0];
        frame_built[11] = req_reg.latitude[15:8];
        frame_built[12] = req_reg.latitude[23:16];
        frame_built[13] = req_reg.latitude[31:24];
        frame_built[14] = req_reg.longitude[7:0];
        frame_built[15] = req_reg.longitude[15:8];
        frame_built[16] = req_reg.longitude[23:16];
        frame_built[17] = req_reg.longitude[31:24];
        frame_built[18] = req_reg.altitude[7:0];
        frame_built[19] = req_reg.altitude[15:8];
        frame_built[20] = req_reg.altitude[23:16];
        frame_built[21] = req_reg.altitude[31:24];
        frame_built[22] = type_tag;
        frame_built[23] = check;
    end

    // Holding stage: filled on accept, emptied when the serialiser loads
    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (load)
        begin
            pend_next = 1'b0;
        end
    end

    // Serialiser next state
    always_comb
    begin
        act_next   = act_reg;
        cnt_next   = cnt_reg;
        frame_next = frame_reg;
        if (load)
        begin
            act_next   = 1'b1;
            cnt_next   = '0;
            frame_next = frame_built;
        end
        else if (act_reg)
        begin
            act_next   = !last;
            cnt_next   = cnt_reg + CNT_W'(1);
            frame_next = {8'h00, frame_reg[FRAME_LEN-1:1]};
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            act_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            act_reg  <= act_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        frame_reg <= frame_next;
    end

    // Result word
    assign strobe            = act_reg;
    assign result.frame_byte = frame_reg[0];
    assign result.frame_end  = last;

    // Checks
    a_end_has_strobe : assert property (@(posedge clk) disable iff (!rst_n)
        result.frame_end |-> strobe)
        else $error("frame end flag without strobe");

    a_frame_contiguous : assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.frame_end |=> strobe)
        else $error("gap inside a frame");

    a_accept_sets_busy : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || strobe)
        else $error("accepted request lost");

    a_pending_follows : assert property (@(posedge clk) disable iff (!rst_n)
        result.frame_end && busy |=> strobe && !result.frame_end)
        else $error("waiting frame not started after last byte");

endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the radio transmit frame builder
// Sends request words and checks every 24-byte frame that comes back,
// byte by byte, against a frame former kept inside the bench, over several
// address and tag offset settings and sender idling patterns.
// ---------------------------------------------------------------------------
module tb_top
    import rtfb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Follower id that selects no address register
    localparam logic [1:0] FOLLOWER_NONE = 2'd3;

    // Directed row: request word, plus typed tag and checksum where known
    typedef struct packed {
        req_t       word;
        logic       typed;
        logic [7:0] tag;
        logic [7:0] fcs;
    } stim_row_t;

    // Typed rows assume the reset register values
    localparam stim_row_t DIRECTED [12] = '{
        '{'{FOLLOWER_0, 32'sh0, 32'sh0, 32'sh0, 8'h02}, 1'b1, 8'h00, 8'hED},
        '{'{FOLLOWER_NONE, 32'sh0, 32'sh0, 32'sh0, KIND_WAYPOINT}, 1'b1, 8'hFF, 8'h54},
        '{'{FOLLOWER_NONE, -32'sd1, -32'sd1, -32'sd1, 8'hFF}, 1'b1, 8'h00, 8'h5F},
        '{'{FOLLOWER_NONE, -32'sd1, -32'sd1, -32'sd1, KIND_WAYPOINT}, 1'b1, 8'h0B, 8'h54},
        '{'{FOLLOWER_1, 32'sh80000000, 32'sh80000000, 32'sh80000000, KIND_ORBIT},
          1'b1, 8'h7F, 8'hCC},
        '{'{FOLLOWER_2, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, KIND_WAYPOINT},
          1'b1, 8'h8B, 8'hAA},
        '{'{FOLLOWER_0, 32'sh12345678, 32'shA5A5A5A5, 32'sh0F1E2D3C, KIND_ORBIT},
          1'b0, 8'h00, 8'h00},
        '{'{FOLLOWER_1, 32'sh7F00FF01, -32'sd1000, 32'sd250000, KIND_WAYPOINT},
          1'b0, 8'h00, 8'h00},
        '{'{FOLLOWER_2, 32'shDEADBEEF, 32'sh00000001, 32'shFFFFFF00, 8'h80},
          1'b0, 8'h00, 8'h00},
        '{'{FOLLOWER_NONE, 32'sh5A5A5A5A, 32'shC3C3C3C3, 32'sh3C3C3C3C, KIND_ORBIT},
          1'b0, 8'h00, 8'h00},
        '{'{FOLLOWER_0, 32'sh00FF00FF, 32'shFF00FF00, 32'sh0, 8'h7F},
          1'b0, 8'h00, 8'h00},
        '{'{FOLLOWER_2, -32'sd1, 32'sd0, 32'sh80000000, KIND_ORBIT},
          1'b0, 8'h00, 8'h00}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    req_t                  req;
    logic                  strobe;
    res_t                  result;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Bench copy of the register file
    logic [15:0] dest_addr [3];
    logic [7:0]  waypoint_off;
    logic [7:0]  orbit_off;

    res_t bytes_due [$];
    int   mismatches = 0;

    radio_tx_frame_builder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .strobe    (strobe),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Form the whole frame for one request word from the current registers
    function automatic frame_t form_frame(input req_t w);
        frame_t       f;
        logic [15:0]  dest;
        logic [95:0]  pos;
        logic [7:0]   pos_sum;
        logic [7:0]   fcs_sum;
        case (w.follower_id)
            FOLLOWER_0: dest = dest_addr[0];
            FOLLOWER_1: dest = dest_addr[1];
            FOLLOWER_2: dest = dest_addr[2];
            default:    dest = 16'h0000;
        endcase
        f[0] = BYTE_DELIM;
        f[1] = BYTE_LEN_HI;
        f[2] = BYTE_LEN_LO;
        f[3] = BYTE_API_ID;
        f[4] = BYTE_FRAME_ID;
        f[5] = dest[15:8];
        f[6] = dest[7:0];
        f[7] = BYTE_OPTION;
        f[8] = BYTE_TAG_A;
        f[9] = BYTE_TAG_B;
        // latitude, longitude, altitude, each LSB first
        pos = {w.altitude, w.longitude, w.latitude};
        pos_sum = 8'h00;
        for (int k = 0; k < 12; k++)
        begin
            f[10+k] = pos[8*k +: 8];
            pos_sum += f[10+k];
        end
        if (w.packet_kind == KIND_WAYPOINT)
            f[22] = BYTE_FULL - pos_sum + waypoint_off;
        else if (w.packet_kind == KIND_ORBIT)
            f[22] = BYTE_FULL - pos_sum + orbit_off;
        else
            f[22] = 8'h00;
        fcs_sum = 8'h00;
        for (int k = 3; k < 23; k++)
            fcs_sum += f[k];
        f[23] = BYTE_FULL - fcs_sum;
        return f;
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("%0t ns frame check: %s got %02h want %02h", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one request word, optionally after an idle gap; called at a falling edge
    task automatic send_word(input req_t w, input int idle_pct, input logic typed,
                             input logic [7:0] tag, input logic [7:0] fcs);
        frame_t f;
        res_t   r;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start <= 1'b1;
        req   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // word taken at this edge: queue its 24 bytes
        f = form_frame(w);
        if (typed)
        begin
            f[22] = tag;
            f[23] = fcs;
        end
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            r.frame_byte = f[i];
            r.frame_end  = (i == FRAME_LEN - 1);
            bytes_due.push_back(r);
        end
        @(negedge clk);
    endtask

    // One register write per falling edge; caller lowers cfg_write afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_FOLLOWER0: dest_addr[0] = data;
            CFG_FOLLOWER1: dest_addr[1] = data;
            CFG_FOLLOWER2: dest_addr[2] = data;
            CFG_WAYPT_OFF: waypoint_off = data[7:0];
            CFG_ORBIT_OFF: orbit_off    = data[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Wait until every queued byte is out, then let the pipeline settle
    task automatic drain();
        while (bytes_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Coordinates: extremes often, otherwise any 32-bit value
    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 32'sh80000000;
            1:       return 32'sh7FFFFFFF;
            2:       return 32'sh0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly waypoint and orbit words, the rest any kind
    function automatic logic [7:0] pick_kind();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return KIND_WAYPOINT;
            4, 5, 6, 7: return KIND_ORBIT;
            default:    return 8'($urandom);
        endcase
    endfunction

    // Result checker: every strobed word against the oldest expected byte
    always @(posedge clk)
    begin : frame_check
        res_t due;
        if (rst_n && strobe)
        begin
            if (bytes_due.size() == 0)
                note_mismatch("unexpected byte", result.frame_byte, 8'h00);
            else
            begin
                due = bytes_due.pop_front();
                if (result.frame_byte !== due.frame_byte)
                    note_mismatch("frame_byte", result.frame_byte, due.frame_byte);
                if (result.frame_end !== due.frame_end)
                    note_mismatch("frame_end", 8'(result.frame_end), 8'(due.frame_end));
            end
        end
    end

    // Main sequence
    initial
    begin
        req_t w;
        int   idle_pct;
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        dest_addr[0] = FOLLOWER0_RST;
        dest_addr[1] = FOLLOWER1_RST;
        dest_addr[2] = FOLLOWER2_RST;
        waypoint_off = 8'h00;
        orbit_off    = 8'h00;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words, back to back, reset register values
        for (int i = 0; i < $size(DIRECTED); i++)
            send_word(DIRECTED[i].word, 0, DIRECTED[i].typed,
                      DIRECTED[i].tag, DIRECTED[i].fcs);
        start <= 1'b0;

        // Random phases: sender idles 24%, then 53%, then never
        for (int p = 0; p < 6; p++)
        begin
            idle_pct = (p < 2) ? 24 : (p < 4) ? 53 : 0;
            drain();
            case (p)
                0:
                begin
                    // all ones; offsets take only the low byte
                    write_reg(CFG_FOLLOWER0, 16'hFFFF);
                    write_reg(CFG_FOLLOWER1, 16'hFFFF);
                    write_reg(CFG_FOLLOWER2, 16'hFFFF);
                    write_reg(CFG_WAYPT_OFF, 16'hFFFF);
                    write_reg(CFG_ORBIT_OFF, 16'hFFFF);
                end
                1:
                begin
                    write_reg(CFG_FOLLOWER0, 16'h0000);
                    write_reg(CFG_FOLLOWER1, 16'h0000);
                    write_reg(CFG_FOLLOWER2, 16'h0000);
                    write_reg(CFG_WAYPT_OFF, 16'h0000);
                    write_reg(CFG_ORBIT_OFF, 16'h0000);
                end
                default:
                begin
                    write_reg(CFG_FOLLOWER0, 16'($urandom));
                    write_reg(CFG_FOLLOWER1, 16'($urandom));
                    write_reg(CFG_FOLLOWER2, 16'($urandom));
                    write_reg(CFG_WAYPT_OFF, 16'($urandom));
                    write_reg(CFG_ORBIT_OFF, 16'($urandom));
                end
            endcase
            // index beyond the register file must change nothing
            write_reg(CFG_IDX_W'($urandom_range(int'(CFG_ORBIT_OFF) + 1,
                                                (1 << CFG_IDX_W) - 1)),
                      16'($urandom));
            cfg_write <= 1'b0;
            @(negedge clk);

            for (int n = 0; n < 34; n++)
            begin
                w.follower_id = 2'($urandom_range(0, 3));
                w.latitude    = pick_coord();
                w.longitude   = pick_coord();
                w.altitude    = pick_coord();
                w.packet_kind = pick_kind();
                send_word(w, idle_pct, 1'b0, 8'h00, 8'h00);
            end
            start <= 1'b0;
        end

        // Let the last frames out, then a few spare cycles for strays
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
